>>> design/pbslc_pkg.sv
package pbslc_pkg;

    localparam int unsigned MAX_DECODED = 32767;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned OUT_LEN_W   = 15;
    localparam logic [7:0]  HDR_INVALID = 8'h80;

    typedef enum logic [2:0] {
        MODE_HEADER  = 3'b001,
        MODE_LITERAL = 3'b010,
        MODE_REPEAT  = 3'b100
    } pbslc_mode_t;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] length;
        logic                 error;
    } pbslc_result_t;

endpackage

>>> design/packbits_stream_length_check.sv
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_ready  stream_byte[7:0], final_byte
// out       source     out_valid/out_ready  decoded_length[14:0], stream_error
//
// One item per cycle unless a final item waits on a stalled result; out_valid is set as that item steps.
// Path: input register, combinational parser/length update, result register.
// Reset clears the parser state and both valid flags; no clearing pass.
// A stalled result holds the final item in the input register; non-final items keep flowing.
module packbits_stream_length_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] decoded_length,
    output logic        stream_error
);
    import pbslc_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          final_reg;
    logic          advance;
    logic          out_valid_reg;
    pbslc_result_t result_reg;
    pbslc_result_t result_next;

    // a final item needs a free result slot before it can step
    assign advance  = in_valid_reg && (!final_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    pbslc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .step_byte  (byte_reg),
        .step_final (final_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= stream_byte;
            final_reg <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && final_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && final_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign decoded_length = result_reg.length;
    assign stream_error   = result_reg.error;

    a_error_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_error) |-> decoded_length == '0)
        else $error("error result with nonzero length");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(byte_reg)
            && $stable(final_reg)))
        else $error("stalled input item lost");

    a_stall_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (final_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

endmodule

>>> design/pbslc_core.sv
module pbslc_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_en,
    input  logic [7:0]               step_byte,
    input  logic                     step_final,
    output pbslc_pkg::pbslc_result_t result
);
    import pbslc_pkg::*;

    pbslc_mode_t        mode_reg, mode_next;
    logic [7:0]         remain_reg, remain_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic               error_reg, error_next;

    logic [7:0]         amount;
    logic               add_en;
    logic [LEN_W-1:0]   sum;
    logic               final_err;

    always_comb
    begin
        mode_next   = mode_reg;
        remain_next = remain_reg;
        error_next  = error_reg;
        add_en      = 1'b0;
        amount      = 8'd0;
        if (!error_reg)
        begin
            case (mode_reg)
                MODE_LITERAL:
                begin
                    if (remain_reg != 8'd0)
                    begin
                        remain_next = remain_reg - 8'd1;
                    end
                    if (remain_next == 8'd0)
                    begin
                        mode_next = MODE_HEADER;
                    end
                end
                MODE_REPEAT:
                begin
                    mode_next = MODE_HEADER;
                end
                default:
                begin
                    if (!step_byte[7])
                    begin
                        remain_next = {1'b0, step_byte[6:0]} + 8'd1;
                        mode_next   = MODE_LITERAL;
                        amount      = remain_next;
                        add_en      = 1'b1;
                    end
                    else if (step_byte == HDR_INVALID)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        // repeat run worth 257 minus the header
                        mode_next = MODE_REPEAT;
                        amount    = 8'(9'd257 - {1'b0, step_byte});
                        add_en    = 1'b1;
                    end
                end
            endcase
        end

        sum         = length_reg + LEN_W'(amount);
        length_next = length_reg;
        if (add_en)
        begin
            if (sum > LEN_W'(MAX_DECODED))
            begin
                error_next  = 1'b1;
                length_next = '0;
            end
            else
            begin
                length_next = sum;
            end
        end

        final_err     = error_next || (mode_next != MODE_HEADER);
        result.error  = final_err;
        result.length = final_err ? '0 : length_next[OUT_LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HEADER;
            remain_reg <= '0;
            length_reg <= '0;
            error_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            if (step_final)
            begin
                // start the next stream clean
                mode_reg   <= MODE_HEADER;
                remain_reg <= '0;
                length_reg <= '0;
                error_reg  <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                remain_reg <= remain_next;
                length_reg <= length_next;
                error_reg  <= error_next;
            end
        end
    end

    a_literal_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_LITERAL && !error_reg) |-> remain_reg != 8'd0)
        else $error("literal mode with no bytes left to skip");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && step_final) |=>
            (mode_reg == MODE_HEADER && length_reg == '0 && !error_reg))
        else $error("state not cleared after final item");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(MAX_DECODED))
        else $error("running length above maximum");

endmodule
